>>> rtl/cltok_pkg.sv
// cltok_pkg: shared constants for the command line tokenizer.
// Holds parse phase codes, character codes and default widths.
// No dependencies.
package cltok_pkg;

	localparam int RUN_WIDTH_DEF = 16;
	localparam int ARG_INDEX_WIDTH_DEF = 8;

	localparam int PHASE_W = 3;
	localparam logic [PHASE_W-1:0] PH_START  = 3'd0;
	localparam logic [PHASE_W-1:0] PH_NAME_Q = 3'd1;
	localparam logic [PHASE_W-1:0] PH_NAME_U = 3'd2;
	localparam logic [PHASE_W-1:0] PH_SKIP   = 3'd3;
	localparam logic [PHASE_W-1:0] PH_ARG    = 3'd4;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_NUL    = 8'h00;

	localparam int LIT_W = 16;
	localparam int ARGNUM_W = 8;

endpackage

>>> rtl/command_line_tokenizer_core.sv
// command_line_tokenizer_core: splits a command line, one byte per word, into arguments.
// Depends on cltok_pkg for phase codes, character codes and default widths.
//
// Usage:
//   Input channel (in_valid, in_stall, char_byte, line_end) carries one line byte
//   per word; a zero byte or line_end set terminates the line. Output channel
//   (out_valid, out_stall, lit_backslashes, out_char, char_valid, arg_end,
//   arg_number, line_done) carries at most one result word per input word.
//   A word is taken when valid is high and stall is low.
//   Pipeline: an input word is registered, then decoded against the parse state
//   into the result register, which drives the output channel. Throughput is
//   one word per cycle while the receiver does not stall; the parse state (phase,
//   quote flags, backslash run, arg index) is updated as each word is decoded.
//   Words that only update state (backslashes, skipped blanks, quiet quotes)
//   give no result.
//   When the receiver stalls with a result held, the input register fills and
//   in_stall rises the same cycle; nothing is dropped.
//   Reset (arst_n low) clears both valid registers and returns the parser to
//   the start of the program name. A terminator also returns it there.
module command_line_tokenizer_core
	import cltok_pkg::*;
#(
	parameter int RUN_WIDTH = RUN_WIDTH_DEF,
	parameter int ARG_INDEX_WIDTH = ARG_INDEX_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          char_byte,
	input  logic                line_end,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [LIT_W-1:0]    lit_backslashes,
	output logic [7:0]          out_char,
	output logic                char_valid,
	output logic                arg_end,
	output logic [ARGNUM_W-1:0] arg_number,
	output logic                line_done
);

	localparam logic [RUN_WIDTH-1:0] RUN_MAX = '1;
	localparam logic [ARG_INDEX_WIDTH-1:0] ARG_MAX = '1;

	logic                       valid_s1;
	logic [7:0]                 char_s1;
	logic                       end_s1;
	logic                       adv;

	logic [PHASE_W-1:0]         phase_q;
	logic                       qm_q;
	logic                       qp_q;
	logic [RUN_WIDTH-1:0]       run_q;
	logic [ARG_INDEX_WIDTH-1:0] arg_q;

	logic [PHASE_W-1:0]         n_phase;
	logic                       n_qm;
	logic                       n_qp;
	logic [RUN_WIDTH-1:0]       n_run;
	logic [ARG_INDEX_WIDTH-1:0] n_arg;

	logic                       r_vld;
	logic [RUN_WIDTH-1:0]       r_lit;
	logic [7:0]                 r_ch;
	logic                       r_cv;
	logic                       r_ae;
	logic                       r_ld;
	logic [31:0]                lit_ext;
	logic [15:0]                arg_ext;

	logic                       valid_s2;
	logic [LIT_W-1:0]           lit_s2;
	logic [7:0]                 ch_s2;
	logic                       cv_s2;
	logic                       ae_s2;
	logic [ARGNUM_W-1:0]        argn_s2;
	logic                       ld_s2;

	assign adv      = !valid_s2 || !out_stall;
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv || !valid_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			char_s1 <= char_byte;
			end_s1  <= line_end;
		end
	end

	always_comb begin
		logic term;
		logic blank;
		logic is_q;
		logic do_arg;
		logic clr;
		logic bump;
		logic pend_hit;
		logic [RUN_WIDTH-1:0] half;

		term     = end_s1 || (char_s1 == CH_NUL);
		blank    = (char_s1 == CH_SPACE) || (char_s1 == CH_TAB);
		is_q     = (char_s1 == CH_QUOTE);
		do_arg   = 1'b0;
		clr      = 1'b0;
		bump     = 1'b0;
		pend_hit = 1'b0;
		half     = '0;

		n_phase = phase_q;
		n_qm    = qm_q;
		n_qp    = qp_q;
		n_run   = run_q;
		n_arg   = arg_q;
		r_vld   = 1'b0;
		r_lit   = '0;
		r_ch    = '0;
		r_cv    = 1'b0;
		r_ae    = 1'b0;
		r_ld    = 1'b0;

		unique case (phase_q)
			PH_NAME_Q: begin
				if (term) begin
					r_vld = 1'b1; r_ae = 1'b1; r_ld = 1'b1; clr = 1'b1;
				end else if (is_q) begin
					r_vld = 1'b1; r_ae = 1'b1; bump = 1'b1; n_phase = PH_SKIP;
				end else begin
					r_vld = 1'b1; r_ch = char_s1; r_cv = 1'b1;
				end
			end
			PH_NAME_U: begin
				if (term) begin
					r_vld = 1'b1; r_ae = 1'b1; r_ld = 1'b1; clr = 1'b1;
				end else if (blank) begin
					r_vld = 1'b1; r_ae = 1'b1; bump = 1'b1; n_phase = PH_SKIP;
				end else begin
					r_vld = 1'b1; r_ch = char_s1; r_cv = 1'b1;
				end
			end
			PH_SKIP: begin
				if (term) begin
					r_vld = 1'b1; r_ld = 1'b1; clr = 1'b1;
				end else if (!blank) begin
					n_phase = PH_ARG;
					n_qm = 1'b0;
					n_qp = 1'b0;
					n_run = '0;
					do_arg = 1'b1;
				end
			end
			PH_ARG: begin
				do_arg = 1'b1;
			end
			default: begin
				if (term) begin
					r_vld = 1'b1; r_ae = 1'b1; r_ld = 1'b1; clr = 1'b1;
				end else if (is_q) begin
					n_phase = PH_NAME_Q;
				end else if (blank) begin
					r_vld = 1'b1; r_ae = 1'b1; bump = 1'b1; n_phase = PH_SKIP;
				end else begin
					n_phase = PH_NAME_U;
					r_vld = 1'b1; r_ch = char_s1; r_cv = 1'b1;
				end
			end
		endcase

		if (do_arg) begin
			if (n_qp) begin
				n_qp = 1'b0;
				n_qm = 1'b0;
				if (!term && is_q) begin
					r_vld = 1'b1; r_ch = CH_QUOTE; r_cv = 1'b1; pend_hit = 1'b1;
				end
			end
			if (!pend_hit) begin
				half = n_run >> 1;
				if (term) begin
					r_vld = 1'b1; r_lit = n_run; r_ae = 1'b1; r_ld = 1'b1; clr = 1'b1;
				end else if (char_s1 == CH_BSLASH) begin
					if (n_run != RUN_MAX) begin
						n_run = n_run + RUN_WIDTH'(1);
					end
				end else if (is_q) begin
					if (n_run[0]) begin
						r_vld = 1'b1; r_lit = half; r_ch = CH_QUOTE; r_cv = 1'b1;
					end else begin
						if (n_qm) begin
							n_qp = 1'b1;
						end else begin
							n_qm = 1'b1;
						end
						if (half != '0) begin
							r_vld = 1'b1; r_lit = half;
						end
					end
					n_run = '0;
				end else if (!n_qm && blank) begin
					r_vld = 1'b1; r_lit = n_run; r_ae = 1'b1;
					n_run = '0; bump = 1'b1; n_phase = PH_SKIP;
				end else begin
					r_vld = 1'b1; r_lit = n_run; r_ch = char_s1; r_cv = 1'b1;
					n_run = '0;
				end
			end
		end

		if (bump && (n_arg != ARG_MAX)) begin
			n_arg = n_arg + ARG_INDEX_WIDTH'(1);
		end

		if (clr) begin
			n_phase = PH_START;
			n_qm = 1'b0;
			n_qp = 1'b0;
			n_run = '0;
			n_arg = '0;
		end
	end

	assign lit_ext = 32'(r_lit);
	assign arg_ext = 16'(arg_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			qm_q    <= 1'b0;
			qp_q    <= 1'b0;
			run_q   <= '0;
			arg_q   <= '0;
		end else if (valid_s1 && adv) begin
			phase_q <= n_phase;
			qm_q    <= n_qm;
			qp_q    <= n_qp;
			run_q   <= n_run;
			arg_q   <= n_arg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1 && r_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1 && r_vld) begin
			lit_s2  <= lit_ext[LIT_W-1:0];
			ch_s2   <= r_ch;
			cv_s2   <= r_cv;
			ae_s2   <= r_ae;
			argn_s2 <= arg_ext[ARGNUM_W-1:0];
			ld_s2   <= r_ld;
		end
	end

	assign out_valid       = valid_s2;
	assign lit_backslashes = lit_s2;
	assign out_char        = ch_s2;
	assign char_valid      = cv_s2;
	assign arg_end         = ae_s2;
	assign arg_number      = argn_s2;
	assign line_done       = ld_s2;

endmodule
